// ----- sv/modular_exponentiation_defines.svh -----
// Assertion macros shared by the modular exponentiation modules.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH
`ifndef SYNTHESIS
`define ME_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ME_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ME_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ME_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/modexp_pkg.sv -----
package modexp_pkg;
  localparam int unsigned QueueDepth = 2;
  typedef struct packed {
    logic busy;
    logic done;
  } modexp_status_t;
endpackage

// ----- sv/modexp_if.sv -----
interface modexp_if #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned FIELDS = 1
) ();
  logic valid;
  logic ready;
  logic [FIELDS*WIDTH-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/modexp_front.sv -----
`include "modular_exponentiation_defines.svh"
module modexp_front #(
  parameter int unsigned WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [WIDTH-1:0] in_base,
  input  logic [WIDTH-1:0] in_exp,
  output logic q_valid,
  input  logic q_ready,
  output logic [WIDTH-1:0] q_base,
  output logic [WIDTH-1:0] q_exp,
  output logic q_zero
);
  import modexp_pkg::*;
  localparam int unsigned PtrW = $clog2(QueueDepth);
  logic [WIDTH-1:0] base_mem [QueueDepth];
  logic [WIDTH-1:0] exp_mem [QueueDepth];
  logic zero_mem [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0] count;
  logic push;
  logic pop;

  assign in_ready = (count != (PtrW+1)'(QueueDepth));
  assign q_valid = (count != '0);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign q_base = base_mem[rd_ptr];
  assign q_exp = exp_mem[rd_ptr];
  assign q_zero = zero_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      base_mem[wr_ptr] <= in_base;
      exp_mem[wr_ptr] <= in_exp;
      zero_mem[wr_ptr] <= (in_exp == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  `ME_ASSERT_IMPL(a_no_overflow, clk, rst, count == (PtrW+1)'(QueueDepth), !push)
  `ME_ASSERT_IMPL(a_no_underflow, clk, rst, count == '0, !pop)
  `ME_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)
endmodule

// ----- sv/modexp_back.sv -----
`include "modular_exponentiation_defines.svh"
module modexp_back #(
  parameter int unsigned WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic [WIDTH-1:0] modulus,
  input  logic q_valid,
  output logic q_ready,
  input  logic [WIDTH-1:0] q_base,
  input  logic [WIDTH-1:0] q_exp,
  input  logic q_zero,
  output logic out_valid,
  input  logic out_ready,
  output logic [WIDTH-1:0] out_result,
  output modexp_pkg::modexp_status_t status
);
  import modexp_pkg::*;
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRed = 3'd1;
  localparam logic [2:0] StStep = 3'd2;
  localparam logic [2:0] StMul = 3'd3;
  localparam logic [2:0] StSq = 3'd4;
  localparam logic [2:0] StOut = 3'd5;

  logic [2:0] state;
  logic [WIDTH-1:0] b;
  logic [WIDTH-1:0] e;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] m;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] mm_acc;
  logic [WIDTH-1:0] mm_add;
  logic [WIDTH-1:0] mm_b;
  logic [$clog2(WIDTH+1)-1:0] cnt;
  logic res_valid;
  logic [WIDTH-1:0] res;

  function automatic logic [WIDTH-1:0] add_mod(
    input logic [WIDTH-1:0] x, input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] md);
    logic [WIDTH-1:0] room;
    room = md - y;
    if (md == '0) return x + y;
    if (x >= room) return x - room;
    return x + y;
  endfunction

  logic [WIDTH:0] rem_sh;
  assign rem_sh = {rem, b[WIDTH-1]};

  assign q_ready = (state == StIdle) && !res_valid;
  assign out_valid = res_valid;
  assign out_result = res;
  assign status.busy = (state != StIdle);
  assign status.done = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      res_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) res_valid <= 1'b0;
      case (state)
        StIdle: begin
          if (q_valid && q_ready) begin
            m <= modulus;
            e <= q_exp;
            b <= q_base;
            rem <= '0;
            cnt <= '0;
            acc <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
            if (q_zero) begin
              res <= WIDTH'(1);
              res_valid <= 1'b1;
            end else if (modulus == '0) begin
              state <= StStep;
            end else begin
              state <= StRed;
            end
          end
        end
        StRed: begin
          // Restoring remainder, one bit a cycle.
          b <= {b[WIDTH-2:0], 1'b0};
          if (rem_sh >= {1'b0, m}) rem <= WIDTH'(rem_sh - {1'b0, m});
          else rem <= rem_sh[WIDTH-1:0];
          cnt <= cnt + 1'b1;
          if (cnt == ($clog2(WIDTH+1))'(WIDTH-1)) begin
            state <= StStep;
          end
        end
        StStep: begin
          if (cnt == ($clog2(WIDTH+1))'(WIDTH)) begin
            b <= rem;
            cnt <= '0;
          end else if (e == '0) begin
            state <= StOut;
          end else if (e[0]) begin
            mm_acc <= '0;
            mm_add <= acc;
            mm_b <= b;
            state <= StMul;
          end else begin
            e <= e >> 1;
            if ((e >> 1) != '0) begin
              mm_acc <= '0;
              mm_add <= b;
              mm_b <= b;
              state <= StSq;
            end
          end
        end
        StMul, StSq: begin
          if (mm_b == '0) begin
            if (state == StMul) begin
              acc <= mm_acc;
              e <= e >> 1;
              if ((e >> 1) != '0) begin
                mm_acc <= '0;
                mm_add <= b;
                mm_b <= b;
                state <= StSq;
              end else begin
                state <= StStep;
              end
            end else begin
              b <= mm_acc;
              state <= StStep;
            end
          end else begin
            if (mm_b[0]) mm_acc <= add_mod(mm_acc, mm_add, m);
            mm_add <= add_mod(mm_add, mm_add, m);
            mm_b <= mm_b >> 1;
          end
        end
        StOut: begin
          if (!res_valid) begin
            res <= acc;
            res_valid <= 1'b1;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  `ME_ASSERT_IMPL(a_ready_idle, clk, rst, q_ready, state == StIdle)
  `ME_ASSERT_NEXT(a_zero_done, clk, rst, q_valid && q_ready && q_zero, res_valid && res == WIDTH'(1))
  `ME_ASSERT_IMPL(a_step_bound, clk, rst, state == StMul || state == StSq, m == '0 || mm_add < m)
endmodule

// ----- sv/modular_exponentiation.sv -----
// Computes base_value to the power exponent modulo the configured modulus (reset 1; zero
// means 2^WIDTH). An exponent of zero gives 1. Items enter a two-word queue and are processed
// one at a time by a single shift-add modular multiplier: the base is first reduced by a
// restoring remainder, then each exponent bit takes a step state and a multiply pass when the
// bit is set, plus a squaring pass for every bit but the top one.
module modular_exponentiation #(
  parameter int unsigned WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [WIDTH-1:0] cfg_wdata,
  modexp_if.sink   in_ch,
  modexp_if.source out_ch
);
  import modexp_pkg::*;
  logic [WIDTH-1:0] modulus;
  logic q_valid;
  logic q_ready;
  logic [WIDTH-1:0] q_base;
  logic [WIDTH-1:0] q_exp;
  logic q_zero;
  modexp_status_t status;
  logic [WIDTH-1:0] res;

  always_ff @(posedge clk) begin
    if (rst) modulus <= WIDTH'(1);
    else if (cfg_we) modulus <= cfg_wdata;
  end

  modexp_front #(.WIDTH(WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_base(in_ch.data[WIDTH-1:0]), .in_exp(in_ch.data[2*WIDTH-1:WIDTH]),
    .q_valid(q_valid), .q_ready(q_ready), .q_base(q_base), .q_exp(q_exp), .q_zero(q_zero)
  );

  modexp_back #(.WIDTH(WIDTH)) u_back (
    .clk(clk), .rst(rst), .modulus(modulus),
    .q_valid(q_valid), .q_ready(q_ready), .q_base(q_base), .q_exp(q_exp), .q_zero(q_zero),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_result(res), .status(status)
  );

  assign out_ch.data = res & {WIDTH{status.done | ~status.done}};
endmodule

// ----- sim/tb_modular_exponentiation.sv -----
`timescale 1ns / 1ps

module tb_modular_exponentiation;
  localparam int unsigned WIDTH = 32;
  localparam int unsigned STALL_LIMIT = 30000;

  typedef struct {
    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] base_value;
    logic [WIDTH-1:0] exponent;
    bit               typed;
    logic [WIDTH-1:0] power_result;
  } vector_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [WIDTH-1:0] cfg_wdata;

  modexp_if #(.WIDTH(WIDTH), .FIELDS(2)) in_ch ();
  modexp_if #(.WIDTH(WIDTH), .FIELDS(1)) out_ch ();

  modular_exponentiation #(.WIDTH(WIDTH)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  logic [WIDTH-1:0] modulus_reg;
  logic [WIDTH-1:0] next_power;
  logic [WIDTH-1:0] power_q[$];
  int error_count;
  int quiet_cycles;
  bit no_gaps;

  vector_t directed[] = '{
    '{32'd1, 32'd0, 32'd0, 1'b1, 32'd1},
    '{32'd1, 32'hFFFFFFFF, 32'd0, 1'b1, 32'd1},
    '{32'd1, 32'd7, 32'd3, 1'b1, 32'd0},
    '{32'd1, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 32'd0},
    '{32'd0, 32'd2, 32'd31, 1'b1, 32'h80000000},
    '{32'd0, 32'd2, 32'd32, 1'b1, 32'd0},
    '{32'd0, 32'hFFFFFFFF, 32'd0, 1'b1, 32'd1},
    '{32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'd0},
    '{32'd0, 32'd0, 32'd5, 1'b1, 32'd0},
    '{32'd0, 32'd3, 32'd1, 1'b1, 32'd3},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1, 1'b1, 32'd0},
    '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'd2, 1'b1, 32'd1},
    '{32'hFFFFFFFF, 32'hFFFFFFFE, 32'hFFFFFFFF, 1'b0, 32'd0},
    '{32'hFFFFFFFF, 32'h12345678, 32'h9ABCDEF0, 1'b0, 32'd0},
    '{32'hFFFFFFFF, 32'd0, 32'd0, 1'b1, 32'd1},
    '{32'd3233, 32'd65, 32'd17, 1'b0, 32'd0},
    '{32'd3233, 32'd2790, 32'd2753, 1'b0, 32'd0},
    '{32'd3233, 32'hFFFFFFFF, 32'h80000001, 1'b0, 32'd0},
    '{32'd2, 32'd5, 32'd7, 1'b1, 32'd1},
    '{32'h80000000, 32'd3, 32'hFFFFFFFF, 1'b0, 32'd0}
  };

  function automatic logic [WIDTH-1:0] power_mod(logic [WIDTH-1:0] base_value,
                                                 logic [WIDTH-1:0] exponent,
                                                 logic [WIDTH-1:0] modulus);
    longint unsigned m;
    longint unsigned b;
    longint unsigned acc;
    logic [WIDTH-1:0] e;
    m = (modulus == 0) ? (64'd1 << WIDTH) : modulus;
    if (exponent == 0) begin
      return 1;
    end
    e = exponent;
    b = base_value % m;
    acc = (m == 1) ? 0 : 1;
    while (e != 0) begin
      if (e[0]) begin
        acc = (acc * b) % m;
      end
      e = e >> 1;
      b = (b * b) % m;
    end
    return acc[WIDTH-1:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      power_q.push_back(next_power);
    end
    if (out_ch.valid && out_ch.ready) begin
      if (power_q.size() == 0) begin
        $display("%0t: unexpected word, actual %h", $time, out_ch.data);
        error_count++;
      end else begin
        if (out_ch.data !== power_q[0]) begin
          $display("%0t: power_result expected %h actual %h", $time, power_q[0],
                   out_ch.data);
          error_count++;
        end
        void'(power_q.pop_front());
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_word(logic [WIDTH-1:0] base_value, logic [WIDTH-1:0] exponent,
                           bit typed, logic [WIDTH-1:0] typed_power);
    int gap;
    @(negedge clk);
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    next_power = typed ? typed_power : power_mod(base_value, exponent, modulus_reg);
    in_ch.data = {exponent, base_value};
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (power_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_modulus(logic [WIDTH-1:0] value);
    drain();
    cfg_wdata = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    modulus_reg = value;
  endtask

  initial begin
    logic [WIDTH-1:0] moduli[6];
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] e;
    int n;
    error_count = 0;
    quiet_cycles = 0;
    no_gaps = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    next_power = '0;
    modulus_reg = 1;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      if (directed[i].modulus != modulus_reg) begin
        write_modulus(directed[i].modulus);
      end
      send_word(directed[i].base_value, directed[i].exponent, directed[i].typed,
                directed[i].power_result);
    end

    moduli[0] = 32'hFFFFFFFF;
    moduli[1] = 0;
    moduli[2] = $urandom | 32'h80000000;
    moduli[3] = $urandom_range(1, 255);
    moduli[4] = $urandom;
    moduli[5] = 32'hFFFFFFFB;
    foreach (moduli[p]) begin
      write_modulus(moduli[p]);
      for (n = 0; n < 42; n++) begin
        if (n % 14 == 0) begin
          no_gaps = ($urandom_range(0, 2) == 0);
        end
        b = $urandom;
        case ($urandom_range(0, 3))
          0: e = $urandom_range(0, 15);
          1: e = $urandom >> $urandom_range(0, 31);
          default: e = $urandom;
        endcase
        send_word(b, e, 1'b0, '0);
      end
    end
    no_gaps = 1'b0;

    drain();
    repeat (100) @(negedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
